// ===== rtl/stepper_home_and_center_defines.svh =====
// ----------------------------------------------------------------------------
// stepper_home_and_center_defines
// assertion macros used by the homing sequencer rtl
// ----------------------------------------------------------------------------
`ifndef STEPPER_HOME_AND_CENTER_DEFINES_SVH
`define STEPPER_HOME_AND_CENTER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SHC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define SHC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// shc_pkg
// types and constants of the stepper homing and centring sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package shc_pkg;

   // width of the travel step counter
   localparam int COUNT_BITS = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // register reset values
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd2000;
   localparam logic [7:0]  CHUNK_STEPS_RESET = 8'd5;

   // register indexes
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_CHUNK_STEPS = 1'b1;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LEFT   = 3'd1,
      PH_RIGHT  = 3'd2,
      PH_CENTER = 3'd3
   } phase_type;

   // one request: a timer tick with its inputs
   typedef struct packed {
      logic start_req;
      logic left_limit;
      logic right_limit;
   } req_type;

   // one response per tick
   typedef struct packed {
      logic        step_level;
      logic        direction;
      logic        enable_n;
      logic        busy_res;
      logic        done_res;
      logic [15:0] travel_steps;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/stepper_home_and_center.sv =====
// ----------------------------------------------------------------------------
// stepper_home_and_center
// homing and centring sequencer for a stepper driver, one request per tick
// ----------------------------------------------------------------------------
// Takes one request (timer tick) every clock cycle and returns one response
// per request. The response is valid once the request has passed the request
// register and the response register. The request register holds the tick
// while the sequencer update runs into the response register. With no stall on the
// response side a request is taken at every edge. A stalled response holds
// the request register and the sequencer state together, so no tick is lost.
// The user must write registers through the csr port only while no request or
// response is in flight; the block does not enforce it. A write during a run
// takes effect at the next pulse or chunk load.
`default_nettype none

module stepper_home_and_center
   import shc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data,
   // register write port
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

`include "stepper_home_and_center_defines.svh"

   // registers
   logic [15:0]           half_period_ff;
   logic [7:0]            chunk_steps_ff;

   logic                  s1_valid_ff, s1_valid_in;
   req_type               s1_req_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   phase_type             phase_ff, phase_in;
   logic [15:0]           timer_ff, timer_in;
   logic                  pulse_ff, pulse_in;
   logic [7:0]            chunk_ff, chunk_in;
   logic [COUNT_BITS-1:0] travel_ff, travel_in;
   logic [COUNT_BITS-1:0] center_ff, center_in;
   logic                  done_in;

   logic                  s2_take, s1_adv, req_acc;
   logic [15:0]           half_eff;
   logic [7:0]            chunk_eff;
   logic                  step_end, chk_left, chk_right;
   logic [7:0]            chunk_dec;
   logic [COUNT_BITS+15:0] travel_wide;

   // handshake
   assign s2_take   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && s2_take;
   assign req_stall = s1_valid_ff && !s2_take;
   assign req_acc   = req_valid && !req_stall;

   assign s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // zero settings act as one
   assign half_eff  = (half_period_ff == 16'd0) ? 16'd1 : half_period_ff;
   assign chunk_eff = (chunk_steps_ff == 8'd0) ? 8'd1 : chunk_steps_ff;

   // next state of the sequencer for the request in the input register
   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      pulse_in  = pulse_ff;
      chunk_in  = chunk_ff;
      travel_in = travel_ff;
      center_in = center_ff;
      done_in   = 1'b0;
      step_end  = 1'b0;
      chk_left  = 1'b0;
      chk_right = 1'b0;
      chunk_dec = (chunk_ff != 8'd0) ? chunk_ff - 8'd1 : 8'd0;

      // pulse timer: high half, low half, then step ends
      if (phase_ff == PH_LEFT || phase_ff == PH_RIGHT || phase_ff == PH_CENTER) begin
         if (timer_ff > 16'd1) begin
            timer_in = timer_ff - 16'd1;
         end else if (pulse_ff) begin
            pulse_in = 1'b0;
            timer_in = half_eff;
         end else begin
            timer_in = 16'd0;
            step_end = 1'b1;
         end
      end

      case (phase_ff)
         PH_LEFT: begin
            if (step_end) begin
               chunk_in = chunk_dec;
               if (chunk_dec == 8'd0) begin
                  chk_left = 1'b1;
               end else begin
                  pulse_in = 1'b1;
                  timer_in = half_eff;
               end
            end
         end
         PH_RIGHT: begin
            if (step_end) begin
               if (travel_ff != COUNT_MAX) begin
                  travel_in = travel_ff + 1'b1;
               end
               chunk_in = chunk_dec;
               if (chunk_dec == 8'd0) begin
                  chk_right = 1'b1;
               end else begin
                  pulse_in = 1'b1;
                  timer_in = half_eff;
               end
            end
         end
         PH_CENTER: begin
            if (step_end) begin
               if (center_ff <= COUNT_BITS'(1)) begin
                  phase_in  = PH_IDLE;
                  pulse_in  = 1'b0;
                  timer_in  = 16'd0;
                  chunk_in  = 8'd0;
                  center_in = '0;
                  done_in   = 1'b1;
               end else begin
                  center_in = center_ff - 1'b1;
                  pulse_in  = 1'b1;
                  timer_in  = half_eff;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (s1_req_ff.start_req) begin
               travel_in = '0;
               chk_left  = 1'b1;
            end
         end
      endcase

      // left limit check at a chunk boundary
      if (chk_left) begin
         if (s1_req_ff.left_limit) begin
            chk_right = 1'b1;
         end else begin
            phase_in = PH_LEFT;
            chunk_in = chunk_eff;
            pulse_in = 1'b1;
            timer_in = half_eff;
         end
      end

      // right limit check, may go straight on to centring or completion
      if (chk_right) begin
         if (s1_req_ff.right_limit) begin
            center_in = travel_in >> 1;
            if ((travel_in >> 1) == '0) begin
               phase_in  = PH_IDLE;
               pulse_in  = 1'b0;
               timer_in  = 16'd0;
               chunk_in  = 8'd0;
               center_in = '0;
               done_in   = 1'b1;
            end else begin
               phase_in = PH_CENTER;
               pulse_in = 1'b1;
               timer_in = half_eff;
            end
         end else begin
            phase_in = PH_RIGHT;
            chunk_in = chunk_eff;
            pulse_in = 1'b1;
            timer_in = half_eff;
         end
      end
   end

   // response fields from the updated state
   assign travel_wide = {16'd0, travel_in};

   always_comb begin
      rsp_in.step_level = pulse_in;
      rsp_in.direction  = (phase_in == PH_LEFT) || (phase_in == PH_CENTER);
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.enable_n   = (phase_in == PH_IDLE);
      rsp_in.done_res   = done_in;
      rsp_in.travel_steps = (travel_wide > (COUNT_BITS+16)'(16'hFFFF)) ?
                            16'hFFFF : travel_wide[15:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
         chunk_steps_ff <= CHUNK_STEPS_RESET;
         phase_ff       <= PH_IDLE;
         timer_ff       <= 16'd0;
         pulse_ff       <= 1'b0;
         chunk_ff       <= 8'd0;
         travel_ff      <= '0;
         center_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_PERIOD: half_period_ff <= csr_wdata;
               CSR_CHUNK_STEPS: chunk_steps_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (s1_adv) begin
            phase_ff  <= phase_in;
            timer_ff  <= timer_in;
            pulse_ff  <= pulse_in;
            chunk_ff  <= chunk_in;
            travel_ff <= travel_in;
            center_ff <= center_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // checks
   `SHC_ASSERT_NOW(a_done_not_busy, rsp_valid_ff && rsp_ff.done_res, !rsp_ff.busy_res,
      "completing response shows busy")
   `SHC_ASSERT_NOW(a_idle_quiet, phase_ff == PH_IDLE, !pulse_ff && timer_ff == 16'd0,
      "step pulse or timer active while idle")
   `SHC_ASSERT_NOW(a_center_only, phase_ff != PH_CENTER, center_ff == '0,
      "centring count left outside centring")
   `SHC_ASSERT_NEXT(a_travel_mono, phase_ff != PH_IDLE, travel_ff >= $past(travel_ff),
      "travel count dropped during a run")

endmodule

`default_nettype wire
